@@ hdl/rts_pkg.sv @@
// Package with shared types and constants of the task scheduler.
package rts_pkg;

  localparam logic [3:0] ACT_TICK      = 4'd0;
  localparam logic [3:0] ACT_CREATE    = 4'd1;
  localparam logic [3:0] ACT_SET_ALARM = 4'd2;
  localparam logic [3:0] ACT_WAIT_ALRM = 4'd3;
  localparam logic [3:0] ACT_SET_EVENT = 4'd4;
  localparam logic [3:0] ACT_WAIT_EVT  = 4'd5;
  localparam logic [3:0] ACT_MTX_GET   = 4'd6;
  localparam logic [3:0] ACT_MTX_REL   = 4'd7;
  localparam logic [3:0] ACT_YIELD     = 4'd8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic [3:0] NONE_ID = 4'd15;

  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  target_task;
    logic [15:0] tick_count_req;
    logic [7:0]  event_bits;
    logic [1:0]  mutex_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  run_task;
    logic [1:0]  status;
    logic [7:0]  events;
    logic [31:0] tick_total;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic tick_step;
    logic sched;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_sched;
  } dp_stat_t;

endpackage

@@ hdl/rts_datapath.sv @@
// Datapath holding the scheduler state, the command logic and the alarm walk.
module rts_datapath #(
  parameter int TASKS   = 8,
  parameter int MUTEXES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rts_pkg::dp_cmd_t    cmd,
  input  logic [2:0]          walk_idx,
  input  rts_pkg::in_item_t   in_data,
  output rts_pkg::dp_stat_t   stat,
  output rts_pkg::out_item_t  result
);

  localparam logic [3:0] IDLE_ID = 4'(TASKS);

  rts_pkg::in_item_t cmd_r;
  logic [TASKS-1:0]  ready_r;
  logic [15:0]       alarm_r [TASKS];
  logic [7:0]        pend_r [TASKS];
  logic [7:0]        wait_r [TASKS];
  logic [3:0]        owner_r [MUTEXES];
  logic [3:0]        mwait_r [TASKS+1];
  logic [3:0]        cur_r;
  logic [31:0]       ticks_r;
  logic [1:0]        status_r;
  logic [7:0]        events_r;
  logic              sched_r;

  logic [3:0] pick;
  logic [3:0] m;
  logic [3:0] own;
  logic       cur_ok;
  logic       tgt_ok;
  logic       mid_ok;
  logic [2:0] cur3;
  logic [7:0] evw;

  assign cur_ok = cur_r < IDLE_ID;
  assign cur3   = cur_r[2:0];
  assign tgt_ok = 32'(cmd_r.target_task) < TASKS;
  assign mid_ok = 32'(cmd_r.mutex_id) < MUTEXES;
  assign evw    = (pend_r[cmd_r.target_task] | cmd_r.event_bits) & wait_r[cmd_r.target_task];

  always_comb begin
    pick = IDLE_ID;
    for (int t = TASKS - 1; t >= 0; t--) begin
      if (ready_r[t]) pick = 4'(t);
    end
    m   = mwait_r[pick];
    own = IDLE_ID;
    if (32'(m) < MUTEXES) own = owner_r[m[1:0]];
    if (32'(m) < MUTEXES && own != rts_pkg::NONE_ID) begin
      if (own < IDLE_ID && ready_r[own[2:0]]) pick = own;
      else pick = IDLE_ID;
    end
  end

  assign stat.is_tick    = cmd_r.action == rts_pkg::ACT_TICK;
  assign stat.need_sched = sched_r;
  assign result = '{run_task: cur_r, status: status_r, events: events_r,
                    tick_total: ticks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
      cur_r   <= IDLE_ID;
      ticks_r <= '0;
      sched_r <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        alarm_r[i] <= '0;
        pend_r[i]  <= '0;
        wait_r[i]  <= '0;
      end
      for (int i = 0; i < MUTEXES; i++) owner_r[i] <= rts_pkg::NONE_ID;
      for (int i = 0; i <= TASKS; i++) mwait_r[i] <= rts_pkg::NONE_ID;
    end else begin
      if (cmd.load) begin
        cmd_r    <= in_data;
        status_r <= rts_pkg::ST_DONE;
        events_r <= '0;
        sched_r  <= 1'b0;
      end
      if (cmd.exec) begin
        case (cmd_r.action)
          rts_pkg::ACT_TICK: begin
            ticks_r <= ticks_r + 32'd1;
            sched_r <= 1'b1;
          end
          rts_pkg::ACT_CREATE: if (tgt_ok) ready_r[cmd_r.target_task] <= 1'b1;
          rts_pkg::ACT_SET_ALARM:
            if (tgt_ok) alarm_r[cmd_r.target_task] <= cmd_r.tick_count_req;
          rts_pkg::ACT_WAIT_ALRM: begin
            if (!cur_ok) status_r <= rts_pkg::ST_REFUSED;
            else if (alarm_r[cur3] != '0) begin
              ready_r[cur3] <= 1'b0;
              sched_r <= 1'b1;
              status_r <= rts_pkg::ST_BLOCKED;
            end
          end
          rts_pkg::ACT_SET_EVENT: begin
            if (tgt_ok) begin
              if ((cmd_r.event_bits & wait_r[cmd_r.target_task]) != '0) begin
                events_r <= evw;
                pend_r[cmd_r.target_task] <=
                  (pend_r[cmd_r.target_task] | cmd_r.event_bits) & ~evw;
                wait_r[cmd_r.target_task] <= '0;
                ready_r[cmd_r.target_task] <= 1'b1;
                sched_r <= 1'b1;
              end else begin
                pend_r[cmd_r.target_task] <=
                  pend_r[cmd_r.target_task] | cmd_r.event_bits;
              end
            end
          end
          rts_pkg::ACT_WAIT_EVT: begin
            if (!cur_ok) status_r <= rts_pkg::ST_REFUSED;
            else if ((cmd_r.event_bits & pend_r[cur3]) != '0) begin
              events_r <= pend_r[cur3] & cmd_r.event_bits;
              pend_r[cur3] <= pend_r[cur3] & ~cmd_r.event_bits;
            end else begin
              wait_r[cur3] <= cmd_r.event_bits;
              ready_r[cur3] <= 1'b0;
              sched_r <= 1'b1;
              status_r <= rts_pkg::ST_BLOCKED;
            end
          end
          rts_pkg::ACT_MTX_GET: begin
            if (mid_ok && cur_r <= IDLE_ID) begin
              if (owner_r[cmd_r.mutex_id] == rts_pkg::NONE_ID) begin
                owner_r[cmd_r.mutex_id] <= cur_r;
                mwait_r[cur_r] <= rts_pkg::NONE_ID;
              end else begin
                mwait_r[cur_r] <= 4'(cmd_r.mutex_id);
                sched_r <= 1'b1;
                status_r <= rts_pkg::ST_BLOCKED;
              end
            end
          end
          rts_pkg::ACT_MTX_REL: begin
            if (mid_ok) begin
              owner_r[cmd_r.mutex_id] <= rts_pkg::NONE_ID;
              sched_r <= 1'b1;
            end
          end
          rts_pkg::ACT_YIELD: sched_r <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.tick_step && alarm_r[walk_idx] != '0) begin
        alarm_r[walk_idx] <= alarm_r[walk_idx] - 16'd1;
        if (alarm_r[walk_idx] == 16'd1) ready_r[walk_idx] <= 1'b1;
      end
      if (cmd.sched) cur_r <= pick;
    end
  end

endmodule

@@ hdl/rts_ctrl.sv @@
// Controller sequencing command load, execution, alarm walk and scheduling.
module rts_ctrl #(
  parameter int TASKS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  rts_pkg::dp_stat_t stat,
  output rts_pkg::dp_cmd_t  cmd,
  output logic [2:0]        walk_idx,
  output logic              busy,
  output logic              out_valid
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_SCHED, S_OUT} state_t;

  state_t     state_r;
  logic [2:0] idx_r;

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign walk_idx  = idx_r;

  always_comb begin
    cmd = '0;
    cmd.load      = in_fire;
    cmd.exec      = state_r == S_EXEC;
    cmd.tick_step = state_r == S_WALK;
    cmd.sched     = state_r == S_SCHED && stat.need_sched;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) state_r <= S_EXEC;
        S_EXEC: begin
          idx_r <= '0;
          if (stat.is_tick) state_r <= S_WALK;
          else state_r <= S_SCHED;
        end
        S_WALK: begin
          idx_r <= idx_r + 3'd1;
          if (32'(idx_r) == TASKS - 1) state_r <= S_SCHED;
        end
        S_SCHED: state_r <= S_OUT;
        S_OUT: if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/rtos_task_scheduler.sv @@
// Top level of the fixed-priority task scheduler.
//  Channel | Direction | Content
//  in_     | input     | one kernel command per transfer
//  out_    | output    | one result per command
// A tick walks the alarm counters, one per cycle, before scheduling; other
// commands go from execution straight to scheduling and the result.
// Reset is synchronous; all state but the command, status and events registers is cleared.
// The result holds in the output register while out_ready is low, and no
// new command is taken until it is transferred.
module rtos_task_scheduler #(
  parameter int TASKS   = 8,
  parameter int MUTEXES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rts_pkg::out_item_t out_data
);

  rts_pkg::dp_cmd_t  cmd;
  rts_pkg::dp_stat_t stat;
  logic [2:0]        walk_idx;
  logic              busy;

  assign in_ready = !busy;

  rts_ctrl #(.TASKS(TASKS)) u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_valid && in_ready),
    .out_fire (out_valid && out_ready),
    .stat, .cmd, .walk_idx, .busy, .out_valid
  );

  rts_datapath #(.TASKS(TASKS), .MUTEXES(MUTEXES)) u_dp (
    .clk, .rst_n, .cmd, .walk_idx, .in_data, .stat, .result(out_data)
  );

endmodule

@@ test/tb_rtos_task_scheduler.sv @@
// Self-checking testbench of the task scheduler with a built-in kernel model.
module tb_rtos_task_scheduler;

  localparam int NTASK = 8;
  localparam int NMTX  = 4;
  localparam logic [3:0] IDLE_ID = 4'd8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rts_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rts_pkg::out_item_t out_data;

  always #6 clk = ~clk;

  rtos_task_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Kernel state kept by the testbench.
  logic [7:0]  k_ready;
  logic [15:0] k_alarm [NTASK];
  logic [7:0]  k_pend [NTASK];
  logic [7:0]  k_wait [NTASK];
  logic [3:0]  k_owner [NMTX];
  logic [3:0]  k_mwait [NTASK+1];
  logic [3:0]  k_cur;
  logic [31:0] k_ticks;

  rts_pkg::in_item_t  cmd_q [$];
  rts_pkg::out_item_t result_q [$];
  int errors = 0;
  bit hold_rx = 1'b0;
  bit drain_req = 1'b0;

  function automatic logic [3:0] pick_next();
    logic [3:0] nxt;
    logic [3:0] m;
    nxt = IDLE_ID;
    for (int t = NTASK - 1; t >= 0; t--) begin
      if (k_ready[t]) nxt = 4'(t);
    end
    m = k_mwait[nxt];
    if (m < NMTX && k_owner[m] != rts_pkg::NONE_ID) begin
      nxt = k_owner[m];
      if (nxt >= NTASK || !k_ready[nxt]) nxt = IDLE_ID;
    end
    return nxt;
  endfunction

  task automatic kernel_reset();
    k_ready = '0;
    for (int i = 0; i < NTASK; i++) begin
      k_alarm[i] = '0;
      k_pend[i] = '0;
      k_wait[i] = '0;
    end
    for (int i = 0; i < NMTX; i++) k_owner[i] = rts_pkg::NONE_ID;
    for (int i = 0; i <= NTASK; i++) k_mwait[i] = rts_pkg::NONE_ID;
    k_cur = IDLE_ID;
    k_ticks = '0;
  endtask

  task automatic kernel_step(input rts_pkg::in_item_t c, output rts_pkg::out_item_t r);
    logic [3:0] cur;
    logic [2:0] tg;
    logic [1:0] st;
    logic [7:0] ev;
    cur = k_cur;
    tg = c.target_task;
    st = rts_pkg::ST_DONE;
    ev = '0;
    case (c.action)
      rts_pkg::ACT_TICK: begin
        k_ticks++;
        for (int t = 0; t < NTASK; t++) begin
          if (k_alarm[t] != 0) begin
            k_alarm[t]--;
            if (k_alarm[t] == 0) k_ready[t] = 1'b1;
          end
        end
        k_cur = pick_next();
      end
      rts_pkg::ACT_CREATE: k_ready[tg] = 1'b1;
      rts_pkg::ACT_SET_ALARM: k_alarm[tg] = c.tick_count_req;
      rts_pkg::ACT_WAIT_ALRM: begin
        if (cur >= NTASK) st = rts_pkg::ST_REFUSED;
        else if (k_alarm[cur] != 0) begin
          k_ready[cur] = 1'b0;
          k_cur = pick_next();
          st = rts_pkg::ST_BLOCKED;
        end
      end
      rts_pkg::ACT_SET_EVENT: begin
        k_pend[tg] |= c.event_bits;
        if ((c.event_bits & k_wait[tg]) != 0) begin
          ev = k_pend[tg] & k_wait[tg];
          k_pend[tg] &= ~ev;
          k_wait[tg] = '0;
          k_ready[tg] = 1'b1;
          k_cur = pick_next();
        end
      end
      rts_pkg::ACT_WAIT_EVT: begin
        if (cur >= NTASK) st = rts_pkg::ST_REFUSED;
        else if ((c.event_bits & k_pend[cur]) != 0) begin
          ev = k_pend[cur] & c.event_bits;
          k_pend[cur] &= ~c.event_bits;
        end else begin
          k_wait[cur] = c.event_bits;
          k_ready[cur] = 1'b0;
          k_cur = pick_next();
          st = rts_pkg::ST_BLOCKED;
        end
      end
      rts_pkg::ACT_MTX_GET: begin
        if (k_owner[c.mutex_id] == rts_pkg::NONE_ID) begin
          k_owner[c.mutex_id] = cur;
          k_mwait[cur] = rts_pkg::NONE_ID;
        end else begin
          k_mwait[cur] = {2'b00, c.mutex_id};
          k_cur = pick_next();
          st = rts_pkg::ST_BLOCKED;
        end
      end
      rts_pkg::ACT_MTX_REL: begin
        k_owner[c.mutex_id] = rts_pkg::NONE_ID;
        k_cur = pick_next();
      end
      rts_pkg::ACT_YIELD: k_cur = pick_next();
      default: ;
    endcase
    r.run_task = k_cur;
    r.status = st;
    r.events = ev;
    r.tick_total = k_ticks;
  endtask

  function automatic rts_pkg::in_item_t make_cmd(logic [3:0] a, logic [2:0] tg,
                                                 logic [15:0] tk, logic [7:0] eb,
                                                 logic [1:0] m);
    rts_pkg::in_item_t c;
    c.action = a;
    c.target_task = tg;
    c.tick_count_req = tk;
    c.event_bits = eb;
    c.mutex_id = m;
    return c;
  endfunction

  function automatic rts_pkg::in_item_t random_cmd();
    rts_pkg::in_item_t c;
    logic [3:0] a;
    c = rts_pkg::in_item_t'($bits(rts_pkg::in_item_t)'({$urandom, $urandom}));
    if ($urandom_range(0, 19) == 0) a = 4'($urandom_range(9, 15));
    else a = 4'($urandom_range(0, 8));
    c.action = a;
    if ($urandom_range(0, 7) != 0) c.tick_count_req = 16'($urandom_range(0, 6));
    if ($urandom_range(0, 2) == 0) c.event_bits = 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) c.action = rts_pkg::ACT_TICK;
    if ($urandom_range(0, 5) == 0) c.action = rts_pkg::ACT_CREATE;
    return c;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (cmd_q.size() > 0 && !drain_req && burst_left > 0) begin
          in_data <= cmd_q.pop_front();
          burst_left <= burst_left - 1;
        end else begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end
      end else if (!in_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (cmd_q.size() > 0 && !drain_req) begin
          in_data <= cmd_q.pop_front();
          in_valid <= 1'b1;
          burst_left <= $urandom_range(0, 30);
        end
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= (stall_phase + 1) % 97;
      if (hold_rx) out_ready <= 1'b0;
      else if (stall_phase < 40) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: predict on accepted commands, compare on accepted results.
  always @(posedge clk) begin
    rts_pkg::out_item_t r;
    rts_pkg::out_item_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        kernel_step(in_data, r);
        result_q.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result transfer %p", out_data);
        end else begin
          e = result_q.pop_front();
          if (out_data.run_task !== e.run_task || out_data.status !== e.status ||
              out_data.events !== e.events || out_data.tick_total !== e.tick_total) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    rts_pkg::in_item_t c;
    kernel_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, every action and the corner cases.
    cmd_q.push_back(make_cmd(rts_pkg::ACT_WAIT_ALRM, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_WAIT_EVT, 3'd0, 16'd0, 8'hff, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_MTX_GET, 3'd0, 16'd0, 8'h00, 2'd3));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_CREATE, 3'd7, 16'hffff, 8'hff, 2'd3));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_TICK, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_MTX_GET, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_MTX_GET, 3'd0, 16'd0, 8'h00, 2'd3));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_CREATE, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_YIELD, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_MTX_GET, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_MTX_REL, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_SET_ALARM, 3'd0, 16'hffff, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_SET_ALARM, 3'd7, 16'd1, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_WAIT_EVT, 3'd0, 16'd0, 8'h81, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_SET_EVENT, 3'd0, 16'd0, 8'h7f, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_SET_EVENT, 3'd0, 16'd0, 8'h80, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_WAIT_EVT, 3'd0, 16'd0, 8'h03, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_WAIT_EVT, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_WAIT_ALRM, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_TICK, 3'd0, 16'd0, 8'h00, 2'd0));
    cmd_q.push_back(make_cmd(4'd9, 3'd5, 16'h1234, 8'h55, 2'd1));
    cmd_q.push_back(make_cmd(4'd15, 3'd2, 16'hffff, 8'hff, 2'd3));
    cmd_q.push_back(make_cmd(rts_pkg::ACT_SET_ALARM, 3'd0, 16'd0, 8'h00, 2'd0));
    wait_drained();

    // Receiver held off while commands keep coming.
    for (int i = 0; i < 40; i++) cmd_q.push_back(random_cmd());
    hold_rx = 1'b1;
    for (int i = 0; i < 300; i++) @(posedge clk);
    hold_rx = 1'b0;
    wait_drained();

    for (int i = 0; i < 1450; i++) begin
      c = random_cmd();
      cmd_q.push_back(c);
      if (i == 700) begin
        wait_drained();
        drain_req = 1'b1;
        for (int k = 0; k < 30; k++) @(posedge clk);
        drain_req = 1'b0;
      end
    end
    wait_drained();
    for (int k = 0; k < 50; k++) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
